// ===== sv/ltwa_pkg.sv =====
// Shared types and constants for the link table with aging.
package ltwa_pkg;

  localparam int NODE_W        = 7;
  localparam int STAMP_W       = 32;
  localparam int TMO_W         = 16;
  localparam int ENTRY_W       = STAMP_W + 1;
  localparam int MAX_NODES_DEF = 64;
  localparam int GROW_MARGIN   = 5;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 16;
  localparam int IN_DATA_W     = 16;
  localparam int OUT_DATA_W    = 8;

  typedef enum logic [1:0] {
    ACT_JOIN    = 2'd0,
    ACT_QUERY   = 2'd1,
    ACT_DISJOIN = 2'd2,
    ACT_TICK    = 2'd3
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NODE_LIMIT = 1'b0,
    CFG_TIMEOUT    = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CALC,
    ST_READ,
    ST_EVAL,
    ST_DISJ,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic               linked;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

endpackage

// ===== sv/link_table_with_aging_core.sv =====
// Link table with aging: lower-triangular pair store, sequencer and shared slot unit.
//
// One item is processed at a time; in_tready is high only while the sequencer is idle,
// and a finished result waits in the output register without holding off the next item.
// A tick goes from idle straight to done; a join passes through calc, a query through calc,
// read and eval, and a disjoin through calc and a walk over the node's entries that writes
// one store entry per cycle through the single write port; all slot addresses come from
// one shared index multiplier. After reset a clearing pass writes every store entry once
// before the first item is taken; configuration writes are taken at all times.
// tdata fields from bit 0 up: input action[1:0], node_a[8:2], node_b[15:9];
// output status[0], alive[1].
module link_table_with_aging_core #(
  parameter int MAX_NODES = ltwa_pkg::MAX_NODES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [ltwa_pkg::IN_DATA_W-1:0]   in_tdata,   // action, node_a, node_b
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [ltwa_pkg::OUT_DATA_W-1:0]  out_tdata,  // status, alive, zero pad
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ltwa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ltwa_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int NW          = ltwa_pkg::NODE_W;
  localparam int SW          = ltwa_pkg::STAMP_W;
  localparam int PW          = 2 * NW;
  localparam int STORE_DEPTH = MAX_NODES * (MAX_NODES + 1) / 2;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int IDX_MAX     = (1 << NW) - 1;
  localparam logic [NW-1:0] MAX_IDX = NW'((MAX_NODES > IDX_MAX) ? IDX_MAX : MAX_NODES);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_DEPTH - 1);

  ltwa_pkg::state_t state_r, state_nxt;

  logic [NW-1:0]            node_limit_r;
  logic [ltwa_pkg::TMO_W-1:0] timeout_r;
  logic [NW-1:0]            active_r, active_nxt;
  logic [SW-1:0]            seconds_r, seconds_nxt;

  ltwa_pkg::action_t        act_r, act_nxt;
  logic [NW-1:0]            a_r, a_nxt, b_r, b_nxt;
  logic [NW-1:0]            idx_r, idx_nxt;
  logic [ADDR_W-1:0]        clr_r, clr_nxt;

  logic                     status_r, status_nxt;
  logic                     alive_r, alive_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic                     out_status_r, out_status_nxt;
  logic                     out_alive_r, out_alive_nxt;

  logic                     we_r, we_nxt;
  logic [ADDR_W-1:0]        addr_r, addr_nxt;
  ltwa_pkg::entry_t         wdata_r, wdata_nxt;
  ltwa_pkg::entry_t         rdata_r;
  logic [ltwa_pkg::ENTRY_W-1:0] mem [STORE_DEPTH];

  logic [NW-1:0]            hi, lo, lim;
  logic [NW-1:0]            su_hi, su_lo;
  logic [PW-1:0]            su_hi_x, su_prod, su_sum;
  logic [ADDR_W-1:0]        su_slot;
  logic [NW:0]              want;
  logic [NW-1:0]            want_cap;
  logic [SW-1:0]            age;
  logic                     in_xfer;

  assign in_xfer    = in_tvalid && in_tready;
  assign in_tready  = (state_r == ltwa_pkg::ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(ltwa_pkg::OUT_DATA_W - 2){1'b0}}, out_alive_r, out_status_r};

  assign hi  = (a_r > b_r) ? a_r : b_r;
  assign lo  = (a_r > b_r) ? b_r : a_r;
  assign lim = (node_limit_r < MAX_IDX) ? node_limit_r : MAX_IDX;

  // shared slot unit: hi*(hi-1)/2 + lo-1
  always_comb begin
    if (state_r == ltwa_pkg::ST_DISJ) begin
      su_hi = (idx_r > a_r) ? idx_r : a_r;
      su_lo = (idx_r > a_r) ? a_r : idx_r;
    end else begin
      su_hi = hi;
      su_lo = lo;
    end
    su_hi_x = PW'(su_hi);
    su_prod = su_hi_x * (su_hi_x - PW'(1));
    su_sum  = (su_prod >> 1) + PW'(su_lo) - PW'(1);
    su_slot = ADDR_W'(su_sum);
  end

  assign want     = {1'b0, hi} + (NW + 1)'(ltwa_pkg::GROW_MARGIN);
  assign want_cap = (want > {1'b0, lim}) ? lim : want[NW-1:0];
  assign age      = seconds_r - rdata_r.stamp;

  always_comb begin
    state_nxt      = state_r;
    active_nxt     = active_r;
    seconds_nxt    = seconds_r;
    act_nxt        = act_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    idx_nxt        = idx_r;
    clr_nxt        = clr_r;
    status_nxt     = status_r;
    alive_nxt      = alive_r;
    we_nxt         = 1'b0;
    addr_nxt       = addr_r;
    wdata_nxt      = wdata_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_alive_nxt  = out_alive_r;

    unique case (state_r)
      ltwa_pkg::ST_CLEAR: begin
        we_nxt    = 1'b1;
        addr_nxt  = clr_r;
        wdata_nxt = '0;
        clr_nxt   = clr_r + ADDR_W'(1);
        if (clr_r == LAST_ADDR) begin
          state_nxt = ltwa_pkg::ST_IDLE;
        end
      end
      ltwa_pkg::ST_IDLE: begin
        if (in_xfer) begin
          act_nxt    = ltwa_pkg::action_t'(in_tdata[1:0]);
          a_nxt      = in_tdata[2 +: NW];
          b_nxt      = in_tdata[2 + NW +: NW];
          status_nxt = 1'b0;
          alive_nxt  = 1'b0;
          if (ltwa_pkg::action_t'(in_tdata[1:0]) == ltwa_pkg::ACT_TICK) begin
            seconds_nxt = seconds_r + SW'(1);
            state_nxt   = ltwa_pkg::ST_DONE;
          end else begin
            state_nxt = ltwa_pkg::ST_CALC;
          end
        end
      end
      ltwa_pkg::ST_CALC: begin
        state_nxt = ltwa_pkg::ST_DONE;
        case (act_r)
          ltwa_pkg::ACT_JOIN: begin
            if (lo == '0 || hi > lim) begin
              status_nxt = 1'b1;
            end else begin
              if (hi >= active_r && want_cap > active_r) begin
                active_nxt = want_cap;
              end
              we_nxt    = 1'b1;
              addr_nxt  = su_slot;
              wdata_nxt = '{linked: 1'b1, stamp: seconds_r};
            end
          end
          ltwa_pkg::ACT_QUERY: begin
            if (lo == '0 || hi > active_r || hi > MAX_IDX) begin
              status_nxt = 1'b1;
            end else begin
              addr_nxt  = su_slot;
              state_nxt = ltwa_pkg::ST_READ;
            end
          end
          ltwa_pkg::ACT_DISJOIN: begin
            if (a_r == '0 || a_r > active_r || a_r > MAX_IDX) begin
              status_nxt = 1'b1;
            end else begin
              idx_nxt   = NW'(1);
              state_nxt = ltwa_pkg::ST_DISJ;
            end
          end
          default: ;
        endcase
      end
      ltwa_pkg::ST_READ: begin
        state_nxt = ltwa_pkg::ST_EVAL;
      end
      ltwa_pkg::ST_EVAL: begin
        alive_nxt = rdata_r.linked && (age < SW'(timeout_r));
        state_nxt = ltwa_pkg::ST_DONE;
      end
      ltwa_pkg::ST_DISJ: begin
        we_nxt    = 1'b1;
        addr_nxt  = su_slot;
        wdata_nxt = '0;
        idx_nxt   = idx_r + NW'(1);
        if (idx_r == active_r) begin
          state_nxt = ltwa_pkg::ST_DONE;
        end
      end
      ltwa_pkg::ST_DONE: begin
        // hand the result over once the output register is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_alive_nxt  = alive_r;
          state_nxt      = ltwa_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ltwa_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ltwa_pkg::ST_CLEAR;
      clr_r        <= '0;
      active_r     <= '0;
      seconds_r    <= '0;
      out_valid_r  <= 1'b0;
      we_r         <= 1'b0;
      node_limit_r <= NW'(64);
      timeout_r    <= ltwa_pkg::TMO_W'(60);
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      active_r    <= active_nxt;
      seconds_r   <= seconds_nxt;
      out_valid_r <= out_valid_nxt;
      we_r        <= we_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          ltwa_pkg::CFG_NODE_LIMIT: node_limit_r <= cfg_data[NW-1:0];
          ltwa_pkg::CFG_TIMEOUT:    timeout_r    <= cfg_data[ltwa_pkg::TMO_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    act_r        <= act_nxt;
    a_r          <= a_nxt;
    b_r          <= b_nxt;
    idx_r        <= idx_nxt;
    status_r     <= status_nxt;
    alive_r      <= alive_nxt;
    addr_r       <= addr_nxt;
    wdata_r      <= wdata_nxt;
    out_status_r <= out_status_nxt;
    out_alive_r  <= out_alive_nxt;
  end

  // pair store: one registered write port, one registered read port on the same address
  always_ff @(posedge clk) begin
    if (we_r) begin
      mem[addr_r] <= wdata_r;
    end
    rdata_r <= mem[addr_r];
  end

endmodule
